// ----- src/sit_pkg.sv -----
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and codes of the string intern table.
// ----------------------------------------------------------------------------
package sit_pkg;

	localparam logic [2:0] ST_FOUND   = 3'd0;
	localparam logic [2:0] ST_ADDED   = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_ABSENT  = 3'd3;
	localparam logic [2:0] ST_TOOLONG = 3'd4;

	localparam logic CFG_SLOT_COUNT  = 1'b0;
	localparam logic CFG_STORE_LIMIT = 1'b1;

	localparam logic CMD_INTERN = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_SLOT_RD,
		S_SLOT_CHK,
		S_CMP_RD,
		S_CMP_CHK,
		S_DECIDE,
		S_WRITE,
		S_DONE
	} state_t;

endpackage

// ----- src/string_intern_table_top.sv -----
// ----------------------------------------------------------------------------
// string_intern_table_top
// String interning table: buffers bytes, hashes, probes an open-addressed
// slot table and appends new strings to a byte store.
// ----------------------------------------------------------------------------
// Feed one byte per request with start while busy is low. Non-zero bytes are
// taken while idle and give no result. A zero byte ends the string. An empty or
// too long string goes straight to the result state. Otherwise busy stays high
// for the hash modulo (one quotient bit a cycle), then a slot memory read and
// check per probed slot plus a read and a check per compared byte on the
// string store port (at most length + 1 bytes per slot, the stored terminator
// included), on a miss a decision state, on an add the writes of the bytes and
// the terminator through the same store port, and the result state. The result
// appears on symbol/status for exactly one cycle with done high; the receiver
// cannot stall, so take it when it shows. Configuration is written through
// cfg_valid and cfg_ready while idle. After reset a clearing pass over all
// SLOTS entries empties the slot table; busy stays high and cfg_ready low until
// it ends.
module string_intern_table_top #(
	parameter int SLOTS       = 1024,
	parameter int STORE_BYTES = 16384,
	parameter int MAX_LEN     = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [7:0]  char_byte,
	output logic        done,
	output logic [13:0] symbol,
	output logic [2:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [14:0] cfg_data
);

	localparam int SW = $clog2(SLOTS);
	localparam int AW = $clog2(STORE_BYTES);
	localparam int LW = $clog2(MAX_LEN + 2);
	localparam int BW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	sit_pkg::state_t state_q, state_d;

	// configuration
	logic [10:0] slot_cfg_q;
	logic [14:0] limit_cfg_q;
	logic [16:0] slots;
	logic [16:0] limit;

	// string capture
	logic [7:0]    buf_mem [MAX_LEN];
	logic [31:0]   hash_q;
	logic [LW-1:0] len_q;
	logic          cmd_q;

	// slot table memory, zero means empty
	logic [13:0]   slot_mem [SLOTS];
	logic [13:0]   slot_rd_s1;
	logic [SW-1:0] clr_q;

	// string store memory
	logic [7:0]    store_mem [STORE_BYTES];
	logic [7:0]    store_rd_s1;
	logic [7:0]    buf_rd_s1;

	// probe control
	logic [31:0]   rem_q;
	logic [5:0]    div_cnt_q;
	logic [16:0]   idx_q;
	logic [16:0]   probes_q;
	logic [13:0]   sym_q;
	logic [LW-1:0] k_q;
	logic          free_q;
	logic [11:0]   count_q;
	logic [16:0]   used_q;
	logic [13:0]   res_sym_q;
	logic [2:0]    res_st_q;

	logic [32:0]   rem_sh;
	logic [16:0]   sym_k;
	logic          k_end;
	logic [LW-1:0] buf_rd_k;

	assign slots = (slot_cfg_q == 11'd0) ? 17'd1 :
		((17'(slot_cfg_q) > 17'(SLOTS)) ? 17'(SLOTS) : 17'(slot_cfg_q));
	assign limit = (17'(limit_cfg_q) > 17'(STORE_BYTES)) ? 17'(STORE_BYTES) :
		17'(limit_cfg_q);

	assign busy      = (state_q != sit_pkg::S_IDLE);
	assign cfg_ready = (state_q == sit_pkg::S_IDLE);
	assign done      = (state_q == sit_pkg::S_DONE);
	assign symbol    = res_sym_q;
	assign status    = res_st_q;

	assign sym_k  = 17'(sym_q) + 17'(k_q);
	assign k_end  = (k_q == len_q);
	// restoring division step: shift in the next hash bit
	assign rem_sh = {rem_q, hash_q[31]};
	// while writing, fetch the next buffer byte ahead of its write into buf_rd_s1
	assign buf_rd_k = (state_q == sit_pkg::S_DECIDE) ? '0 :
		((state_q == sit_pkg::S_WRITE) ? k_q + LW'(1) : k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_cfg_q  <= 11'd1024;
			limit_cfg_q <= 15'd16384;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == sit_pkg::CFG_SLOT_COUNT) begin
				slot_cfg_q <= cfg_data[10:0];
			end else begin
				limit_cfg_q <= cfg_data;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sit_pkg::S_CLEAR:    if (clr_q == SW'(SLOTS - 1)) state_d = sit_pkg::S_IDLE;
			sit_pkg::S_IDLE: begin
				if (start && char_byte == 8'd0) begin
					if (len_q == '0 || len_q > LW'(MAX_LEN)) begin
						state_d = sit_pkg::S_DONE;
					end else begin
						state_d = sit_pkg::S_MOD;
					end
				end
			end
			sit_pkg::S_MOD:      if (div_cnt_q == 6'd31) state_d = sit_pkg::S_SLOT_RD;
			sit_pkg::S_SLOT_RD:  state_d = sit_pkg::S_SLOT_CHK;
			sit_pkg::S_SLOT_CHK: begin
				if (slot_rd_s1 == 14'd0) state_d = sit_pkg::S_DECIDE;
				else state_d = sit_pkg::S_CMP_RD;
			end
			sit_pkg::S_CMP_RD:   state_d = sit_pkg::S_CMP_CHK;
			sit_pkg::S_CMP_CHK: begin
				if (k_end ? (store_rd_s1 == 8'd0) : (store_rd_s1 == buf_rd_s1)) begin
					state_d = k_end ? sit_pkg::S_DONE : sit_pkg::S_CMP_RD;
				end else if (probes_q + 17'd1 >= slots) begin
					state_d = sit_pkg::S_DECIDE;
				end else begin
					state_d = sit_pkg::S_SLOT_RD;
				end
			end
			sit_pkg::S_DECIDE: begin
				if (cmd_q == sit_pkg::CMD_INTERN && free_q &&
				    17'(count_q) + 17'd1 < slots &&
				    !(slots < 17'((count_q + 12'd1)) * 17'd2) &&
				    !(used_q + 17'(len_q) + 17'd1 > limit)) begin
					state_d = sit_pkg::S_WRITE;
				end else begin
					state_d = sit_pkg::S_DONE;
				end
			end
			sit_pkg::S_WRITE:    if (k_end) state_d = sit_pkg::S_DONE;
			sit_pkg::S_DONE:     state_d = sit_pkg::S_IDLE;
			default:             state_d = sit_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sit_pkg::S_CLEAR;
			clr_q   <= '0;
			hash_q  <= '0;
			len_q   <= '0;
			count_q <= '0;
			used_q  <= 17'd1;
		end else begin
			state_q <= state_d;
			if (state_q == sit_pkg::S_CLEAR) begin
				clr_q <= clr_q + SW'(1);
			end
			if (state_q == sit_pkg::S_IDLE && start && char_byte != 8'd0) begin
				if (len_q < LW'(MAX_LEN)) begin
					hash_q <= hash_q ^ ((hash_q << 5) + (hash_q >> 2) + 32'(char_byte));
					len_q  <= len_q + LW'(1);
				end else begin
					len_q <= LW'(MAX_LEN + 1);
				end
			end
			if (state_q == sit_pkg::S_MOD) begin
				hash_q <= {hash_q[30:0], 1'b0};
			end
			if (state_q == sit_pkg::S_WRITE && k_end) begin
				count_q <= (count_q + 12'd1) & 12'h7FF;
				used_q  <= 17'(sym_q) + 17'(len_q) + 17'd1;
			end
			if (state_q == sit_pkg::S_DONE) begin
				hash_q <= '0;
				len_q  <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == sit_pkg::S_IDLE && start) begin
			if (char_byte != 8'd0 && len_q < LW'(MAX_LEN)) begin
				buf_mem[len_q[BW-1:0]] <= char_byte;
			end
			cmd_q     <= cmd;
			rem_q     <= '0;
			div_cnt_q <= '0;
			probes_q  <= '0;
			free_q    <= 1'b0;
			res_sym_q <= '0;
			res_st_q  <= (len_q == '0) ? sit_pkg::ST_FOUND : sit_pkg::ST_TOOLONG;
		end
		unique case (state_q)
			sit_pkg::S_MOD: begin
				div_cnt_q <= div_cnt_q + 6'd1;
				if (rem_sh >= 33'(slots)) rem_q <= 32'(rem_sh - 33'(slots));
				else rem_q <= rem_sh[31:0];
				if (div_cnt_q == 6'd31) begin
					idx_q <= (rem_sh >= 33'(slots)) ? 17'(rem_sh - 33'(slots)) :
						17'(rem_sh);
				end
			end
			sit_pkg::S_SLOT_CHK: begin
				sym_q <= slot_rd_s1;
				k_q   <= '0;
				if (slot_rd_s1 == 14'd0) free_q <= 1'b1;
			end
			sit_pkg::S_CMP_CHK: begin
				if (k_end ? (store_rd_s1 == 8'd0) : (store_rd_s1 == buf_rd_s1)) begin
					if (k_end) begin
						res_sym_q <= sym_q;
						res_st_q  <= sit_pkg::ST_FOUND;
					end else begin
						k_q <= k_q + LW'(1);
					end
				end else begin
					probes_q <= probes_q + 17'd1;
					idx_q    <= (idx_q + 17'd1 == slots) ? 17'd0 : idx_q + 17'd1;
				end
			end
			sit_pkg::S_DECIDE: begin
				sym_q     <= used_q[13:0];
				k_q       <= '0;
				res_sym_q <= '0;
				res_st_q  <= (cmd_q == sit_pkg::CMD_LOOKUP) ? sit_pkg::ST_ABSENT :
					sit_pkg::ST_FULL;
			end
			sit_pkg::S_WRITE: begin
				k_q <= k_q + LW'(1);
				if (k_end) begin
					res_sym_q <= sym_q;
					res_st_q  <= sit_pkg::ST_ADDED;
				end
			end
			default: begin
			end
		endcase
	end

	// slot table port: one read and at most one write a cycle
	always_ff @(posedge clk) begin
		if (state_q == sit_pkg::S_CLEAR) begin
			slot_mem[clr_q] <= '0;
		end else if (state_q == sit_pkg::S_WRITE && k_end) begin
			slot_mem[idx_q[SW-1:0]] <= sym_q;
		end
		slot_rd_s1 <= slot_mem[idx_q[SW-1:0]];
	end

	// string store port and input buffer read
	always_ff @(posedge clk) begin
		if (state_q == sit_pkg::S_WRITE) begin
			store_mem[sym_k[AW-1:0]] <= k_end ? 8'd0 : buf_rd_s1;
		end
		store_rd_s1 <= (sym_k < 17'(STORE_BYTES)) ? store_mem[sym_k[AW-1:0]] : 8'd0;
		buf_rd_s1   <= buf_mem[buf_rd_k[BW-1:0]];
	end

endmodule

// ----- verif/tb_string_intern_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_string_intern_table_top
// Self-checking bench for the string intern table: feeds strings as byte
// requests in random bursts, predicts every symbol/status answer and compares
// each done strobe against the oldest pending answer.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [13:0] symbol;
	logic [2:0]  status;
} intern_answer_t;

class intern_scoreboard;
	localparam int NSLOTS  = 1024;
	localparam int NBYTES  = 16384;
	localparam int LEN_MAX = 64;

	logic [13:0] slot_map [NSLOTS];
	logic [7:0]  store_mem [NBYTES];
	logic [7:0]  pend_bytes [LEN_MAX];
	logic [31:0] hash;
	int          pend_len;
	int          entry_cnt;
	int          used;
	int          slot_cfg;
	int          limit_cfg;
	int          errors;
	intern_answer_t answers [$];

	function new();
		foreach (slot_map[i]) slot_map[i] = '0;
		store_mem[0] = 8'd0;
		hash      = '0;
		pend_len  = 0;
		entry_cnt = 0;
		used      = 1;
		slot_cfg  = 1024;
		limit_cfg = 16384;
		errors    = 0;
	endfunction

	function void set_reg(logic idx, logic [14:0] val);
		if (idx == sit_pkg::CFG_SLOT_COUNT)
			slot_cfg = int'(val[10:0]);
		else
			limit_cfg = int'(val);
	endfunction

	function int pending();
		return answers.size();
	endfunction

	function bit same_text(int off);
		for (int k = 0; k < pend_len; k++) begin
			if (off + k >= NBYTES || store_mem[off + k] != pend_bytes[k])
				return 0;
		end
		return (off + pend_len < NBYTES) ? (store_mem[off + pend_len] == 8'd0) : 1'b1;
	endfunction

	function void push_answer(int sym, logic [2:0] st);
		intern_answer_t a;
		a.symbol = 14'(sym);
		a.status = st;
		answers.push_back(a);
		hash     = '0;
		pend_len = 0;
	endfunction

	// Note one accepted request; a terminator yields one expected answer.
	function void note_request(logic c_md, logic [7:0] c);
		int slots, lim, idx, sym;
		bit free_slot, hit;
		if (c != 8'd0) begin
			if (pend_len < LEN_MAX) begin
				pend_bytes[pend_len] = c;
				hash = hash ^ ((hash << 5) + (hash >> 2) + {24'd0, c});
				pend_len++;
			end else begin
				pend_len = LEN_MAX + 1;
			end
			return;
		end
		if (pend_len == 0) begin
			push_answer(0, sit_pkg::ST_FOUND);
			return;
		end
		if (pend_len > LEN_MAX) begin
			push_answer(0, sit_pkg::ST_TOOLONG);
			return;
		end
		slots = slot_cfg < 1 ? 1 : (slot_cfg > NSLOTS ? NSLOTS : slot_cfg);
		lim   = limit_cfg > NBYTES ? NBYTES : limit_cfg;
		idx   = int'(hash % 32'(slots));
		free_slot = 0;
		hit = 0;
		sym = 0;
		for (int n = 0; n < slots; n++) begin
			sym = int'(slot_map[idx]);
			if (sym == 0) begin
				free_slot = 1;
				break;
			end
			if (same_text(sym)) begin
				hit = 1;
				break;
			end
			idx = (idx + 1 == slots) ? 0 : idx + 1;
		end
		if (hit)
			push_answer(sym, sit_pkg::ST_FOUND);
		else if (c_md == sit_pkg::CMD_LOOKUP)
			push_answer(0, sit_pkg::ST_ABSENT);
		else if (!free_slot || entry_cnt + 1 >= slots || slots < 2 * (entry_cnt + 1)
				|| used + pend_len + 1 > lim)
			push_answer(0, sit_pkg::ST_FULL);
		else begin
			sym = used;
			for (int k = 0; k < pend_len; k++) store_mem[sym + k] = pend_bytes[k];
			store_mem[sym + pend_len] = 8'd0;
			slot_map[idx] = 14'(sym);
			entry_cnt = (entry_cnt + 1) & 16'h7FF;
			used = sym + pend_len + 1;
			push_answer(sym, sit_pkg::ST_ADDED);
		end
	endfunction

	task report(string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	task check_result(logic [13:0] sym, logic [2:0] st);
		intern_answer_t a;
		if (answers.size() == 0) begin
			report($sformatf("unexpected answer symbol=%0d status=%0d", sym, st));
			return;
		end
		a = answers.pop_front();
		if (sym !== a.symbol)
			report($sformatf("symbol %0d, want %0d", sym, a.symbol));
		if (st !== a.status)
			report($sformatf("status %0d, want %0d", st, a.status));
	endtask
endclass

module tb_string_intern_table_top;

	localparam int WATCHDOG_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        cmd = sit_pkg::CMD_INTERN;
	logic [7:0]  char_byte = 8'd0;
	logic        cfg_valid = 1'b0;
	logic        cfg_index = sit_pkg::CFG_SLOT_COUNT;
	logic [14:0] cfg_data = 15'd0;
	logic        busy;
	logic        done;
	logic [13:0] symbol;
	logic [2:0]  status;
	logic        cfg_ready;

	intern_scoreboard sb = new();

	// Small vocabulary so that repeated strings hit stored entries.
	logic [7:0] vocab [24][8];
	int         vocab_len [24];
	int         burst_left = 0;
	int         idle_cycles = 0;

	always #2 clk = ~clk;

	string_intern_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.char_byte (char_byte),
		.done      (done),
		.symbol    (symbol),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Check every answer strobe; count cycles with no traffic for the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(symbol, status);
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d answers pending", sb.pending());
				$display("** string_intern_table_top: FAILED **");
				$finish;
			end
		end
	end

	// Drive one byte request; hold it until the block takes it.
	task send_byte(logic c_md, logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		start     <= 1'b1;
		cmd       <= c_md;
		char_byte <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(c_md, b);
	endtask

	// Send a random-content string of the given length plus its terminator.
	task send_random_text(logic c_md, int n);
		for (int k = 0; k < n; k++) send_byte(c_md, 8'($urandom_range(1, 255)));
		send_byte(c_md, 8'd0);
	endtask

	task send_word(logic c_md, int w, int n);
		for (int k = 0; k < n; k++) send_byte(c_md, vocab[w][k]);
		send_byte(c_md, 8'd0);
	endtask

	// Drain pending answers, then let the block settle before touching registers.
	task wait_idle();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task write_reg(logic idx, logic [14:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task run_random(int n_items);
		int sent, r, w, n;
		logic c_md;
		sent = 0;
		while (sent < n_items) begin
			r    = $urandom_range(99);
			c_md = ($urandom_range(3) == 0) ? sit_pkg::CMD_LOOKUP : sit_pkg::CMD_INTERN;
			w    = $urandom_range(23);
			if (r < 60) begin
				send_word(c_md, w, vocab_len[w]);
				sent += vocab_len[w] + 1;
			end else if (r < 75) begin
				// prefix of a known word: near miss on compare
				n = $urandom_range(1, vocab_len[w]);
				send_word(c_md, w, n);
				sent += n + 1;
			end else if (r < 90) begin
				n = $urandom_range(1, 6);
				send_random_text(c_md, n);
				sent += n + 1;
			end else if (r < 95) begin
				send_byte(c_md, 8'd0);
				sent += 1;
			end else if (r < 97) begin
				// longest accepted length or one past it
				n = 64 + $urandom_range(1);
				send_random_text(c_md, n);
				sent += n + 1;
			end else begin
				n = $urandom_range(7, 20);
				send_random_text(c_md, n);
				sent += n + 1;
			end
		end
	endtask

	initial begin
		foreach (vocab_len[i]) begin
			vocab_len[i] = $urandom_range(1, 8);
			for (int k = 0; k < 8; k++) vocab[i][k] = 8'($urandom_range(1, 255));
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty string both ways, byte extremes, miss, add, hit.
		send_byte(sit_pkg::CMD_INTERN, 8'd0);
		send_byte(sit_pkg::CMD_LOOKUP, 8'd0);
		send_byte(sit_pkg::CMD_LOOKUP, 8'h41);
		send_byte(sit_pkg::CMD_LOOKUP, 8'd0);
		send_byte(sit_pkg::CMD_INTERN, 8'h01);
		send_byte(sit_pkg::CMD_INTERN, 8'hFF);
		send_byte(sit_pkg::CMD_INTERN, 8'd0);
		send_byte(sit_pkg::CMD_INTERN, 8'h01);
		send_byte(sit_pkg::CMD_INTERN, 8'hFF);
		send_byte(sit_pkg::CMD_INTERN, 8'd0);
		send_byte(sit_pkg::CMD_LOOKUP, 8'h01);
		send_byte(sit_pkg::CMD_LOOKUP, 8'hFF);
		send_byte(sit_pkg::CMD_LOOKUP, 8'd0);
		send_byte(sit_pkg::CMD_INTERN, 8'h80);
		send_byte(sit_pkg::CMD_INTERN, 8'd0);
		send_byte(sit_pkg::CMD_LOOKUP, 8'h7F);
		send_byte(sit_pkg::CMD_LOOKUP, 8'd0);
		run_random(480);
		wait_idle();

		// Out-of-range registers clamp to the built-in sizes.
		write_reg(sit_pkg::CFG_SLOT_COUNT, 15'd2047);
		write_reg(sit_pkg::CFG_STORE_LIMIT, 15'd32767);
		run_random(300);
		wait_idle();

		// Shrink the slot count with entries present: table fills fast.
		write_reg(sit_pkg::CFG_SLOT_COUNT, 15'd16);
		write_reg(sit_pkg::CFG_STORE_LIMIT, 15'd16384);
		run_random(220);
		wait_idle();

		write_reg(sit_pkg::CFG_SLOT_COUNT, 15'd0);
		run_random(100);
		wait_idle();

		// Store limit of two: every add is refused.
		write_reg(sit_pkg::CFG_SLOT_COUNT, 15'd1024);
		write_reg(sit_pkg::CFG_STORE_LIMIT, 15'd2);
		run_random(100);
		wait_idle();

		write_reg(sit_pkg::CFG_SLOT_COUNT, 15'd1);
		write_reg(sit_pkg::CFG_STORE_LIMIT, 15'd16384);
		run_random(100);
		wait_idle();

		// Store limit just above current use: adds run out of room.
		write_reg(sit_pkg::CFG_SLOT_COUNT, 15'd1024);
		write_reg(sit_pkg::CFG_STORE_LIMIT, 15'(sb.used + 40));
		run_random(250);
		wait_idle();

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("** string_intern_table_top: PASSED **");
		end else begin
			$display("** string_intern_table_top: FAILED **");
		end
		$finish;
	end

endmodule
